/* hw/rtl/spmc_pkg.sv */
`default_nettype none
package spmc_pkg;

  localparam int DW          = 16;
  localparam int PW          = 2 * DW;
  localparam int ADDR_W      = 6;
  localparam int PDATA_W     = 64;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEPS   = DW / DIV_STAGES;
  localparam int CNT_W       = $clog2(DW);
  localparam logic [7:0] DEFAULT_RADIUS = 8'd3;

  typedef enum logic [2:0] {
    REG_VIEW_X_MIN  = 3'd0,
    REG_VIEW_X_MAX  = 3'd1,
    REG_VIEW_Y_MIN  = 3'd2,
    REG_VIEW_Y_MAX  = 3'd3,
    REG_PLOT_ORIGIN = 3'd4,
    REG_PLOT_SIZE   = 3'd5,
    REG_WORK_REGION = 3'd6,
    REG_RADIUS      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_NEXT,
    ST_FINAL
  } setup_state_t;

  typedef struct packed {
    logic              ok;
    logic signed [DW-1:0] vx0;
    logic signed [DW-1:0] vy0;
    logic [DW-1:0]     rx;
    logic [DW-1:0]     ry;
    logic signed [DW-1:0] plx;
    logic signed [DW-1:0] ply;
    logic [DW-1:0]     sw;
    logic [DW-1:0]     sh;
    logic signed [DW-1:0] wx1;
    logic signed [DW-1:0] wy1;
    logic signed [DW-1:0] wx2;
    logic signed [DW-1:0] wy2;
    logic [7:0]        r;
    logic signed [DW-1:0] dx0;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy0;
    logic signed [DW-1:0] dy1;
  } map_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/spmc_div_stage.sv */
`default_nettype none
module spmc_div_stage #(
  parameter int STEPS = 4
) (
  input  wire logic [spmc_pkg::DW-1:0] rem_i,
  input  wire logic [spmc_pkg::DW-1:0] lo_i,
  input  wire logic [spmc_pkg::DW-1:0] den_i,
  output logic      [spmc_pkg::DW-1:0] rem_o,
  output logic      [spmc_pkg::DW-1:0] lo_o
);

  always_comb begin
    logic [spmc_pkg::DW:0]   t;
    logic [spmc_pkg::DW-1:0] rem;
    logic [spmc_pkg::DW-1:0] lo;
    rem = rem_i;
    lo  = lo_i;
    for (int i = 0; i < STEPS; i++) begin
      t  = {rem, lo[spmc_pkg::DW-1]};
      lo = {lo[spmc_pkg::DW-2:0], 1'b0};
      if (t >= {1'b0, den_i}) begin
        t     = t - {1'b0, den_i};
        lo[0] = 1'b1;
      end
      rem = t[spmc_pkg::DW-1:0];
    end
    rem_o = rem;
    lo_o  = lo;
  end

endmodule
`default_nettype wire

/* hw/rtl/spmc_cfg.sv */
`default_nettype none
module spmc_cfg #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spmc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [spmc_pkg::PDATA_W-1:0]   pwdata,
  output logic      [spmc_pkg::PDATA_W-1:0]   prdata,
  output logic                                busy,
  output spmc_pkg::map_cfg_t                  cfg
);

  localparam int DW = spmc_pkg::DW;
  localparam int EW = ((COORD_BITS > DW + 1) ? COORD_BITS : DW + 1) + 2;

  logic [DW-1:0]  vxmin_r, vxmax_r, vymin_r, vymax_r;
  logic [31:0]    origin_r, size_r;
  logic [63:0]    work_r;
  logic [7:0]     radius_r;

  spmc_pkg::setup_state_t state_r, state_nxt;
  logic [1:0]            job_r;
  logic [spmc_pkg::CNT_W-1:0] cnt_r;
  logic [DW-1:0]         rem_r, lo_r, den_r;
  logic [DW-1:0]         q_r [4];
  logic                  ok_r;
  logic signed [DW-1:0]  dx0_r, dx1_r, dy0_r, dy1_r;

  logic                  wr;
  spmc_pkg::reg_idx_t    idx;
  logic [DW-1:0]         rem_step, lo_step;

  logic signed [DW-1:0]  vx0, vx1, vy0, vy1, plx, ply, wx1, wy1, wx2, wy2;
  logic [DW-1:0]         w, h, sw, sh;
  logic [7:0]            r;
  logic signed [DW+1:0]  rxs, rys;
  logic signed [EW-1:0]  ex1, ey1, ex2, ey2, t;
  logic signed [EW-1:0]  relx0, relx1, rely0, rely1;
  logic                  base_ok, rel_ok;
  logic [DW-1:0]         mul_a, mul_b, den_sel;
  logic [spmc_pkg::PW-1:0] prod;
  logic signed [DW+1:0]  dx0, dx1, dy0, dy1;

  assign wr  = psel && penable && pwrite;
  assign idx = spmc_pkg::reg_idx_t'(paddr[spmc_pkg::ADDR_W-1:3]);

  always_comb begin
    prdata = '0;
    unique case (idx)
      spmc_pkg::REG_VIEW_X_MIN:  prdata = {48'd0, vxmin_r};
      spmc_pkg::REG_VIEW_X_MAX:  prdata = {48'd0, vxmax_r};
      spmc_pkg::REG_VIEW_Y_MIN:  prdata = {48'd0, vymin_r};
      spmc_pkg::REG_VIEW_Y_MAX:  prdata = {48'd0, vymax_r};
      spmc_pkg::REG_PLOT_ORIGIN: prdata = {32'd0, origin_r};
      spmc_pkg::REG_PLOT_SIZE:   prdata = {32'd0, size_r};
      spmc_pkg::REG_WORK_REGION: prdata = work_r;
      spmc_pkg::REG_RADIUS:      prdata = {56'd0, radius_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vxmin_r  <= 16'd0;
      vxmax_r  <= 16'd100;
      vymin_r  <= 16'd0;
      vymax_r  <= 16'd100;
      origin_r <= '0;
      size_r   <= '0;
      work_r   <= '0;
      radius_r <= spmc_pkg::DEFAULT_RADIUS;
    end else if (wr) begin
      unique case (idx)
        spmc_pkg::REG_VIEW_X_MIN:  vxmin_r  <= pwdata[15:0];
        spmc_pkg::REG_VIEW_X_MAX:  vxmax_r  <= pwdata[15:0];
        spmc_pkg::REG_VIEW_Y_MIN:  vymin_r  <= pwdata[15:0];
        spmc_pkg::REG_VIEW_Y_MAX:  vymax_r  <= pwdata[15:0];
        spmc_pkg::REG_PLOT_ORIGIN: origin_r <= pwdata[31:0];
        spmc_pkg::REG_PLOT_SIZE:   size_r   <= pwdata[31:0];
        spmc_pkg::REG_WORK_REGION: work_r   <= pwdata;
        spmc_pkg::REG_RADIUS:      radius_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    vx0 = $signed(vxmin_r);
    vx1 = $signed(vxmax_r);
    vy0 = $signed(vymin_r);
    vy1 = $signed(vymax_r);
    plx = $signed(origin_r[15:0]);
    ply = $signed(origin_r[31:16]);
    w   = size_r[15:0];
    h   = size_r[31:16];
    sw  = w - 16'd1;
    sh  = h - 16'd1;
    wx1 = $signed(work_r[15:0]);
    wy1 = $signed(work_r[31:16]);
    wx2 = $signed(work_r[47:32]);
    wy2 = $signed(work_r[63:48]);
    r   = (radius_r == 8'd0) ? spmc_pkg::DEFAULT_RADIUS : radius_r;
    rxs = (DW+2)'(vx1) - (DW+2)'(vx0);
    rys = (DW+2)'(vy1) - (DW+2)'(vy0);

    t   = EW'(wx1) - EW'($signed({1'b0, r}));
    ex1 = EW'($signed(t[COORD_BITS-1:0]));
    t   = EW'(wy1) - EW'($signed({1'b0, r}));
    ey1 = EW'($signed(t[COORD_BITS-1:0]));
    t   = EW'(wx2) + EW'($signed({1'b0, r}));
    ex2 = EW'($signed(t[COORD_BITS-1:0]));
    t   = EW'(wy2) + EW'($signed({1'b0, r}));
    ey2 = EW'($signed(t[COORD_BITS-1:0]));

    relx0 = ex1 - EW'(plx);
    if (relx0 < 0) relx0 = '0;
    relx1 = ex2 - EW'(plx);
    if (relx1 > EW'($signed({1'b0, sw}))) relx1 = EW'($signed({1'b0, sw}));
    rely0 = ey1 - EW'(ply);
    if (rely0 < 0) rely0 = '0;
    rely1 = ey2 - EW'(ply);
    if (rely1 > EW'($signed({1'b0, sh}))) rely1 = EW'($signed({1'b0, sh}));

    base_ok = (wx2 > wx1) && (wy2 > wy1) && (w > 16'd1) && (h > 16'd1)
              && (rxs > 0) && (rys > 0);
    rel_ok  = (relx0 <= relx1) && (rely0 <= rely1);
  end

  always_comb begin
    case (job_r)
      2'd0:    begin mul_a = relx0[DW-1:0];       mul_b = rxs[DW-1:0]; end
      2'd1:    begin mul_a = relx1[DW-1:0];       mul_b = rxs[DW-1:0]; end
      2'd2:    begin mul_a = sh - rely1[DW-1:0];  mul_b = rys[DW-1:0]; end
      default: begin mul_a = sh - rely0[DW-1:0];  mul_b = rys[DW-1:0]; end
    endcase
    den_sel = job_r[1] ? sh : sw;
    prod    = mul_a * mul_b;
  end

  spmc_div_stage #(.STEPS(1)) u_div (
    .rem_i (rem_r),
    .lo_i  (lo_r),
    .den_i (den_r),
    .rem_o (rem_step),
    .lo_o  (lo_step)
  );

  always_comb begin
    dx0 = (DW+2)'(vx0) + (DW+2)'({2'b0, q_r[0]}) - 18'sd1;
    if (dx0 < (DW+2)'(vx0)) dx0 = (DW+2)'(vx0);
    dx1 = (DW+2)'(vx0) + (DW+2)'({2'b0, q_r[1]}) + 18'sd1;
    if (dx1 > (DW+2)'(vx1)) dx1 = (DW+2)'(vx1);
    dy0 = (DW+2)'(vy0) + (DW+2)'({2'b0, q_r[2]}) - 18'sd1;
    if (dy0 < (DW+2)'(vy0)) dy0 = (DW+2)'(vy0);
    dy1 = (DW+2)'(vy0) + (DW+2)'({2'b0, q_r[3]}) + 18'sd1;
    if (dy1 > (DW+2)'(vy1)) dy1 = (DW+2)'(vy1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spmc_pkg::ST_IDLE:  state_nxt = spmc_pkg::ST_IDLE;
      spmc_pkg::ST_LOAD:  state_nxt = spmc_pkg::ST_DIV;
      spmc_pkg::ST_DIV: begin
        if (cnt_r == spmc_pkg::CNT_W'(DW - 1)) state_nxt = spmc_pkg::ST_NEXT;
      end
      spmc_pkg::ST_NEXT: begin
        state_nxt = (job_r == 2'd3) ? spmc_pkg::ST_FINAL : spmc_pkg::ST_LOAD;
      end
      spmc_pkg::ST_FINAL: state_nxt = spmc_pkg::ST_IDLE;
      default:            state_nxt = spmc_pkg::ST_IDLE;
    endcase
    if (wr) state_nxt = spmc_pkg::ST_LOAD;
  end

  always_comb begin
    busy = (state_r != spmc_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spmc_pkg::ST_LOAD;
      job_r   <= 2'd0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr) begin
        job_r <= 2'd0;
      end else if (state_r == spmc_pkg::ST_NEXT) begin
        job_r <= job_r + 2'd1;
      end
      if (state_r == spmc_pkg::ST_FINAL && !wr) ok_r <= base_ok && rel_ok;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      spmc_pkg::ST_LOAD: begin
        rem_r <= prod[spmc_pkg::PW-1:DW];
        lo_r  <= prod[DW-1:0];
        den_r <= den_sel;
        cnt_r <= '0;
      end
      spmc_pkg::ST_DIV: begin
        rem_r <= rem_step;
        lo_r  <= lo_step;
        cnt_r <= cnt_r + spmc_pkg::CNT_W'(1);
      end
      spmc_pkg::ST_NEXT: q_r[job_r] <= lo_r;
      spmc_pkg::ST_FINAL: begin
        dx0_r <= dx0[DW-1:0];
        dx1_r <= dx1[DW-1:0];
        dy0_r <= dy0[DW-1:0];
        dy1_r <= dy1[DW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg.ok  = ok_r;
    cfg.vx0 = vx0;
    cfg.vy0 = vy0;
    cfg.rx  = rxs[DW-1:0];
    cfg.ry  = rys[DW-1:0];
    cfg.plx = plx;
    cfg.ply = ply;
    cfg.sw  = sw;
    cfg.sh  = sh;
    cfg.wx1 = wx1;
    cfg.wy1 = wy1;
    cfg.wx2 = wx2;
    cfg.wy2 = wy2;
    cfg.r   = r;
    cfg.dx0 = dx0_r;
    cfg.dx1 = dx1_r;
    cfg.dy0 = dy0_r;
    cfg.dy1 = dy1_r;
  end

endmodule
`default_nettype wire

/* hw/rtl/scatter_point_map_and_cull_unit.sv */
`default_nettype none
// channel | ports                                      | accept
// in      | in_point_x/y, in_series_index, in_last_point | in_valid & in_ready
// out     | out_pixel_x/y, out_visible, out_series_tag, out_last_result | out_valid & out_ready
// cfg     | psel penable pwrite paddr pwdata prdata pready | psel & penable & pwrite
// One beat per cycle while in_ready is high; seven register stages (capture, window test
// and multiply, four radix-16 divider stages, map and cull into the output register).
// Each config write or reset starts a window setup on a shared serial divider;
// in_ready is low until it ends.
// Stages hold independently: a bubble drains even while out_ready is low.
module scatter_point_map_and_cull_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [15:0]               in_point_x,
  input  wire logic signed [15:0]               in_point_y,
  input  wire logic [7:0]                       in_series_index,
  input  wire logic                             in_last_point,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [COORD_BITS-1:0]          out_pixel_x,
  output logic signed [COORD_BITS-1:0]          out_pixel_y,
  output logic                                  out_visible,
  output logic [7:0]                            out_series_tag,
  output logic                                  out_last_result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [spmc_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [spmc_pkg::PDATA_W-1:0]     pwdata,
  output logic      [spmc_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int DW = spmc_pkg::DW;
  localparam int NS = spmc_pkg::DIV_STAGES;
  localparam int NST = NS + 3;
  localparam int EW = ((COORD_BITS > DW + 1) ? COORD_BITS : DW + 1) + 2;

  spmc_pkg::map_cfg_t cfg;
  logic               busy;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic signed [DW-1:0] a_x_r, a_y_r;
  logic [7:0]           tag_r [NST];
  logic                 last_r [NST];
  logic                 win_r [NST-2];

  logic [spmc_pkg::PW-1:0] b_px_r, b_py_r;
  logic [DW-1:0] rx_r [NS], lx_r [NS], ry_r [NS], ly_r [NS];
  logic [DW-1:0] rx_n [NS], lx_n [NS], ry_n [NS], ly_n [NS];

  logic                 win;
  logic signed [DW:0]   ax, ay;
  logic [spmc_pkg::PW-1:0] px, py;

  logic signed [EW-1:0] mx_f, my_f, mx, my, rr;
  logic                 vis;

  logic signed [COORD_BITS-1:0] pix_x_r, pix_y_r;
  logic                 vis_r;

  assign pready = 1'b1;

  spmc_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .busy    (busy),
    .cfg     (cfg)
  );

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    in_ready = en[0] && !busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid && in_ready;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_x_r     <= in_point_x;
      a_y_r     <= in_point_y;
      tag_r[0]  <= in_series_index;
      last_r[0] <= in_last_point;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        tag_r[k]  <= tag_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
    if (en[1]) win_r[0] <= win;
    for (int k = 1; k < NST - 2; k++) begin
      if (en[k+1]) win_r[k] <= win_r[k-1];
    end
  end

  always_comb begin
    win = cfg.ok && (a_x_r >= cfg.dx0) && (a_x_r <= cfg.dx1)
          && (a_y_r >= cfg.dy0) && (a_y_r <= cfg.dy1);
    ax  = (DW+1)'(a_x_r) - (DW+1)'(cfg.vx0);
    ay  = (DW+1)'(a_y_r) - (DW+1)'(cfg.vy0);
    px  = ax[DW-1:0] * cfg.sw;
    py  = ay[DW-1:0] * cfg.sh;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_px_r   <= px;
      b_py_r   <= py;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    if (s == 0) begin : g_first
      spmc_div_stage #(.STEPS(spmc_pkg::DIV_STEPS)) u_dx (
        .rem_i (b_px_r[spmc_pkg::PW-1:DW]),
        .lo_i  (b_px_r[DW-1:0]),
        .den_i (cfg.rx),
        .rem_o (rx_n[s]),
        .lo_o  (lx_n[s])
      );
      spmc_div_stage #(.STEPS(spmc_pkg::DIV_STEPS)) u_dy (
        .rem_i (b_py_r[spmc_pkg::PW-1:DW]),
        .lo_i  (b_py_r[DW-1:0]),
        .den_i (cfg.ry),
        .rem_o (ry_n[s]),
        .lo_o  (ly_n[s])
      );
    end else begin : g_rest
      spmc_div_stage #(.STEPS(spmc_pkg::DIV_STEPS)) u_dx (
        .rem_i (rx_r[s-1]),
        .lo_i  (lx_r[s-1]),
        .den_i (cfg.rx),
        .rem_o (rx_n[s]),
        .lo_o  (lx_n[s])
      );
      spmc_div_stage #(.STEPS(spmc_pkg::DIV_STEPS)) u_dy (
        .rem_i (ry_r[s-1]),
        .lo_i  (ly_r[s-1]),
        .den_i (cfg.ry),
        .rem_o (ry_n[s]),
        .lo_o  (ly_n[s])
      );
    end
    always_ff @(posedge clk) begin
      if (en[s+2]) begin
        rx_r[s] <= rx_n[s];
        lx_r[s] <= lx_n[s];
        ry_r[s] <= ry_n[s];
        ly_r[s] <= ly_n[s];
      end
    end
  end

  always_comb begin
    rr   = EW'($signed({1'b0, cfg.r}));
    mx_f = EW'(cfg.plx) + EW'($signed({1'b0, lx_r[NS-1]}));
    my_f = EW'(cfg.ply) + EW'($signed({1'b0, cfg.sh}))
           - EW'($signed({1'b0, ly_r[NS-1]}));
    mx   = EW'($signed(mx_f[COORD_BITS-1:0]));
    my   = EW'($signed(my_f[COORD_BITS-1:0]));
    vis  = win_r[NST-3]
           && !((mx + rr < EW'(cfg.wx1)) || (mx - rr > EW'(cfg.wx2))
                || (my + rr < EW'(cfg.wy1)) || (my - rr > EW'(cfg.wy2)));
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      vis_r           <= vis;
      pix_x_r         <= vis ? mx[COORD_BITS-1:0] : '0;
      pix_y_r         <= vis ? my[COORD_BITS-1:0] : '0;
    end
  end

  assign out_valid       = v_r[NST-1];
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_visible     = vis_r;
  assign out_series_tag  = tag_r[NST-1];
  assign out_last_result = last_r[NST-1];

endmodule
`default_nettype wire
